// ===== hdl/cc20_pkg.sv =====
`timescale 1ns / 1ps

package cc20_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;

   localparam word_type SIGMA0 = 32'h61707865;
   localparam word_type SIGMA1 = 32'h3320646e;
   localparam word_type SIGMA2 = 32'h79622d32;
   localparam word_type SIGMA3 = 32'h6b206574;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] CSR_KEY0     = 3'd0;
   localparam logic [2:0] CSR_KEY1     = 3'd1;
   localparam logic [2:0] CSR_KEY2     = 3'd2;
   localparam logic [2:0] CSR_KEY3     = 3'd3;
   localparam logic [2:0] CSR_NONCE_LO = 3'd4;
   localparam logic [2:0] CSR_NONCE_HI = 3'd5;
   localparam logic [2:0] CSR_START    = 3'd6;

   function automatic word_type rotl32(input word_type x, input int n);
      rotl32 = (x << n) | (x >> (32 - n));
   endfunction

   // keep bytes below the count, clear the rest
   function automatic logic [63:0] byte_mask(input logic [3:0] count);
      logic [63:0] m;
      m = '0;
      for (int j = 0; j < 8; j++) begin
         m[8*j +: 8] = (count > 4'(j)) ? 8'hff : 8'h00;
      end
      byte_mask = m;
   endfunction

endpackage

// ===== hdl/chacha20_stream_cipher.sv =====
// A word at block position 0 (first word of a message or of each 64-byte block) starts a new
//   keystream block and is presented after the ST_ROUND steps and the ST_FINAL state.
// Other words are presented the cycle after their transfer.
// Words are not taken during ST_ROUND and ST_FINAL, nor while a held result is not taken;
//   the rounds run on the four-lane half quarter-round unit, one half step a cycle.
// Reset: synchronous, active high; clears control, message state and CSRs to zero, not the datapath.
`timescale 1ns / 1ps

module chacha20_stream_cipher
   import cc20_pkg::*;
#(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [71:0]           req_tdata,   // data_in[63:0], byte_count[67:64], zero
   input  logic                  req_tlast,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // data_out[63:0], out_byte_count[67:64], zero
   output logic                  rsp_tlast,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int STEPS  = 4 * DOUBLE_ROUNDS;
   localparam int STEP_W = $clog2(STEPS);

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL} state_type;

   state_type         state_ff, state_in;
   block_type         s_ff, s_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [2:0]        wp_ff, wp_in;
   logic              in_msg_ff, in_msg_in;
   word_type          ctr_ff, ctr_in;
   logic [63:0]       data_ff, data_in;
   logic [3:0]        count_ff, count_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_data_ff, rsp_data_in;
   logic [3:0]        rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [63:0]       key_ff [4];
   logic [63:0]       nonce_lo_ff;
   word_type          nonce_hi_ff;
   word_type          start_ff;

   logic              accept;
   logic              csr_write;
   logic [2:0]        csr_idx;
   word_type          init_ctr;
   block_type         init;
   block_type         lane_out;
   logic [63:0]       ks_word;
   logic [63:0]       ks_first;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            key_ff[k] <= '0;
         end
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
         start_ff    <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_KEY0:     key_ff[0]   <= csr_pwdata;
            CSR_KEY1:     key_ff[1]   <= csr_pwdata;
            CSR_KEY2:     key_ff[2]   <= csr_pwdata;
            CSR_KEY3:     key_ff[3]   <= csr_pwdata;
            CSR_NONCE_LO: nonce_lo_ff <= csr_pwdata;
            CSR_NONCE_HI: nonce_hi_ff <= csr_pwdata[31:0];
            CSR_START:    start_ff    <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_KEY0:     csr_prdata = key_ff[0];
         CSR_KEY1:     csr_prdata = key_ff[1];
         CSR_KEY2:     csr_prdata = key_ff[2];
         CSR_KEY3:     csr_prdata = key_ff[3];
         CSR_NONCE_LO: csr_prdata = nonce_lo_ff;
         CSR_NONCE_HI: csr_prdata = {32'd0, nonce_hi_ff};
         CSR_START:    csr_prdata = {32'd0, start_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // initial block state
   assign init_ctr = (state_ff == ST_IDLE && !in_msg_ff) ? start_ff : ctr_ff;

   always_comb begin
      init[0] = SIGMA0;
      init[1] = SIGMA1;
      init[2] = SIGMA2;
      init[3] = SIGMA3;
      for (int k = 0; k < 4; k++) begin
         init[4 + 2*k] = key_ff[k][31:0];
         init[5 + 2*k] = key_ff[k][63:32];
      end
      init[12] = init_ctr;
      init[13] = nonce_lo_ff[31:0];
      init[14] = nonce_lo_ff[63:32];
      init[15] = nonce_hi_ff;
   end

   // four quarter-round lanes, half a quarter round per step
   always_comb begin
      word_type a, b, c, d, t;
      lane_out = s_ff;
      for (int i = 0; i < 4; i++) begin
         a = s_ff[i];
         b = step_ff[1] ? s_ff[4 + ((i+1) % 4)]  : s_ff[4 + i];
         c = step_ff[1] ? s_ff[8 + ((i+2) % 4)]  : s_ff[8 + i];
         d = step_ff[1] ? s_ff[12 + ((i+3) % 4)] : s_ff[12 + i];
         a = a + b;
         t = d ^ a;
         d = step_ff[0] ? rotl32(t, 8) : rotl32(t, 16);
         c = c + d;
         t = b ^ c;
         b = step_ff[0] ? rotl32(t, 7) : rotl32(t, 12);
         lane_out[i] = a;
         if (step_ff[1]) begin
            lane_out[4 + ((i+1) % 4)]  = b;
            lane_out[8 + ((i+2) % 4)]  = c;
            lane_out[12 + ((i+3) % 4)] = d;
         end else begin
            lane_out[4 + i]  = b;
            lane_out[8 + i]  = c;
            lane_out[12 + i] = d;
         end
      end
   end

   always_comb begin
      ks_word = '0;
      for (int j = 0; j < 8; j++) begin
         if (wp_ff == 3'(j)) begin
            ks_word = {s_ff[2*j + 1], s_ff[2*j]};
         end
      end
   end

   assign ks_first = {s_ff[1] + init[1], s_ff[0] + init[0]};

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      step_in      = step_ff;
      wp_in        = wp_ff;
      in_msg_in    = in_msg_ff;
      ctr_in       = ctr_ff;
      data_in      = data_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wp_in     = req_tlast ? 3'd0 : wp_ff + 3'd1;
               in_msg_in = !req_tlast;
               if (wp_ff == 3'd0) begin
                  // start a new keystream block
                  ctr_in   = init_ctr;
                  s_in     = init;
                  step_in  = '0;
                  data_in  = req_tdata[63:0];
                  count_in = req_tdata[67:64];
                  last_in  = req_tlast;
                  state_in = ST_ROUND;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = (req_tdata[63:0] ^ ks_word) & byte_mask(req_tdata[67:64]);
                  rsp_count_in = req_tdata[67:64];
                  rsp_last_in  = req_tlast;
               end
            end
         end
         ST_ROUND: begin
            s_in    = lane_out;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int k = 0; k < 16; k++) begin
               s_in[k] = s_ff[k] + init[k];
            end
            ctr_in       = ctr_ff + 32'd1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = (data_ff ^ ks_first) & byte_mask(count_ff);
            rsp_count_in = count_ff;
            rsp_last_in  = last_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         wp_ff        <= '0;
         in_msg_ff    <= 1'b0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wp_ff        <= wp_in;
         in_msg_ff    <= in_msg_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff         <= s_in;
      data_ff      <= data_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_count_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_round_no_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> !rsp_tvalid)
      else $error("result presented during block rounds");

   a_last_ends_message: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !in_msg_ff && wp_ff == 3'd0)
      else $error("message state not cleared after last word");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      accept && wp_ff == 3'd0 |=> state_ff == ST_ROUND && step_ff == '0)
      else $error("block boundary did not start rounds");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL |=> ctr_ff == $past(ctr_ff) + 32'd1)
      else $error("block counter did not advance");
`endif

endmodule
